>>> src/lsq_pkg.sv
package lsq_pkg;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               last_in_row;
        logic               last_of_set;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic [2:0]         coeff_index;
        logic               singular;
        logic               last_coeff;
    } t_out_item;

    typedef struct packed {
        logic               done;
        logic signed [31:0] coef;
    } t_div_res;

    // Integer quotient bits produced by the divider before rounding.
    localparam int QUO_BITS = 34;

    localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;

endpackage

>>> src/least_squares_normal_equation_solver_core.sv
// Least-squares solver by the normal equations, Q16.16 by default.
// Input: one design matrix element per item, taken when start is high and busy is low.
// The item that ends a row carries the row target; last_of_set ends the final row.
// Configuration: i_cfg_we writes i_cfg_data into the column count (reset value 4);
// write it only while busy is low and no set is partly streamed.
// Elements inside a row are taken on back-to-back cycles. A row end adds the row's
// outer product into the Gram memory, one multiply-accumulate at a time through a
// single 32x32 multiplier. After the last row the block computes up to n+1 exact
// determinants by minor expansion over column subsets, each with a bit-serial
// multiply-accumulate on the wide minor word. Each coefficient then passes
// through the restoring divider.
// Results leave one per column on o_result with o_strobe high for one cycle each;
// the receiver cannot stall, and nothing waits on it. A zero determinant gives n
// results with singular set and zero coefficients.
// Synchronous reset clears the Gram valid bits, the column counter and the control.
module least_squares_normal_equation_solver_core #(
    parameter int MAX_COEFFS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  lsq_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    output logic               busy,
    output logic               o_strobe,
    output lsq_pkg::t_out_item o_result
);

    localparam int CW    = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int CCW   = CW + 1;
    localparam int GAW   = CW + CCW;
    localparam int GD    = 1 << GAW;
    localparam int MD    = 1 << MAX_COEFFS;
    localparam int DET_W = 66 * MAX_COEFFS + 8;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_ACC_I   = 15'b000000000000010,
        S_ACC_XI  = 15'b000000000000100,
        S_ACC_RA  = 15'b000000000001000,
        S_ACC_MUL = 15'b000000000010000,
        S_ACC_WR  = 15'b000000000100000,
        S_D_SET   = 15'b000000001000000,
        S_D_RD    = 15'b000000010000000,
        S_D_LD    = 15'b000000100000000,
        S_D_MUL   = 15'b000001000000000,
        S_D_ADD   = 15'b000010000000000,
        S_D_WR    = 15'b000100000000000,
        S_D_DIV   = 15'b001000000000000,
        S_ZERO    = 15'b010000000000000,
        S_FIN     = 15'b100000000000000
    } t_state;

    t_state                  r_state;
    logic [3:0]              r_cfg;
    logic [CW-1:0]           r_col;
    logic [CW-1:0]           r_i;
    logic [CCW-1:0]          r_j;
    logic [MAX_COEFFS-1:0]   r_s;
    logic [5:0]              r_bit;
    logic                    r_odd;
    logic                    r_neg;
    logic                    r_last;
    logic                    r_cram;
    logic                    r_strobe;
    lsq_pkg::t_out_item      r_out;
    logic signed [31:0]      r_y;
    logic signed [31:0]      r_xi;
    logic signed [31:0]      r_rb;
    logic signed [63:0]      r_prod;
    logic signed [63:0]      r_g_rd;
    logic signed [DET_W-1:0] r_m_rd;
    logic [63:0]             r_mag;
    logic signed [DET_W-1:0] r_p;
    logic signed [DET_W-1:0] r_acc;
    logic signed [DET_W-1:0] r_det;
    logic [GD-1:0]           r_gvld;

    logic signed [31:0]      m_rowbuf [MAX_COEFFS];
    logic signed [63:0]      m_gram   [GD];
    logic signed [DET_W-1:0] m_minor  [MD];

    logic                    accept;
    logic                    row_end;
    logic [3:0]              n_eff;
    logic [3:0]              n_last;
    logic [3:0]              col_cur;
    logic [3:0]              col_inc;
    logic [CW-1:0]           col_idx;
    logic [CW-1:0]           col_nxt;
    logic                    j_is_n;
    logic                    j_is_last;
    logic                    i_is_last;
    logic [CW-1:0]           jlow;
    logic [MAX_COEFFS-1:0]   j_mask;
    logic                    s_bit;
    logic                    odd;
    logic [3:0]              row4;
    logic [MAX_COEFFS:0]     full_w;
    logic                    s_full;
    logic [CCW-1:0]          acc_col;
    logic [CCW-1:0]          det_col;
    logic [GAW-1:0]          g_addr;
    logic                    g_re;
    logic                    g_we;
    logic signed [63:0]      g_wdata;
    logic [MAX_COEFFS-1:0]   m_raddr;
    logic                    m_re;
    logic                    m_we;
    logic [CW-1:0]           rb_addr;
    logic [63:0]             g_mag;
    logic                    div_start;
    lsq_pkg::t_div_res       div_res;

    function automatic logic [3:0] popcount(input logic [MAX_COEFFS-1:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int k = 0; k < MAX_COEFFS; k++) begin
            c = c + 4'(v[k]);
        end
        return c;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return sum[63:0];
    endfunction

    always_comb begin
        if (r_cfg == 4'd0) begin
            n_eff = 4'd1;
        end else if (r_cfg > 4'(MAX_COEFFS)) begin
            n_eff = 4'(MAX_COEFFS);
        end else begin
            n_eff = r_cfg;
        end
    end

    assign n_last    = n_eff - 4'd1;
    assign busy      = (r_state != S_IDLE);
    assign accept    = start & ~busy;
    assign row_end   = i_item.last_in_row | i_item.last_of_set;
    assign col_cur   = (4'(r_col) < n_eff) ? 4'(r_col) : n_last;
    assign col_idx   = col_cur[CW-1:0];
    assign col_inc   = col_cur + 4'd1;
    assign col_nxt   = (col_inc < n_eff) ? col_inc[CW-1:0] : n_last[CW-1:0];

    assign j_is_n    = (4'(r_j) == n_eff);
    assign j_is_last = (4'(r_j) == n_last);
    assign i_is_last = (4'(r_i) == n_last);
    assign jlow      = r_j[CW-1:0];
    assign j_mask    = MAX_COEFFS'(1) << jlow;
    assign s_bit     = |(r_s & j_mask);
    assign odd       = ^(r_s & (j_mask - MAX_COEFFS'(1)));
    // The minor for a subset of k columns uses the bottom k rows.
    assign row4      = n_eff - popcount(r_s);
    assign full_w    = ((MAX_COEFFS + 1)'(1) << n_eff) - (MAX_COEFFS + 1)'(1);
    assign s_full    = (r_s == full_w[MAX_COEFFS-1:0]);

    // The X^T y vector lives in the Gram memory as an extra column.
    assign acc_col   = j_is_n ? CCW'(MAX_COEFFS) : r_j;
    assign det_col   = (r_cram && jlow == r_i) ? CCW'(MAX_COEFFS) : r_j;
    assign g_addr    = (r_state == S_D_RD) ? {row4[CW-1:0], det_col} : {r_i, acc_col};
    assign g_re      = (r_state == S_ACC_RA) || ((r_state == S_D_RD) && s_bit);
    assign g_we      = (r_state == S_ACC_WR);
    assign g_wdata   = sat_add(r_g_rd, r_prod);

    assign m_raddr   = r_s & ~j_mask;
    assign m_re      = (r_state == S_D_RD) && s_bit;
    assign m_we      = (r_state == S_D_WR) && !s_full;

    assign rb_addr   = (r_state == S_ACC_I) ? r_i : jlow;
    assign g_mag     = r_g_rd[63] ? (~r_g_rd + 64'd1) : r_g_rd;
    assign div_start = (r_state == S_D_WR) && s_full && r_cram;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            m_rowbuf[col_idx] <= i_item.x_value;
        end
        r_rb <= m_rowbuf[rb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            m_gram[g_addr] <= g_wdata;
        end
        if (g_re) begin
            r_g_rd <= r_gvld[g_addr] ? m_gram[g_addr] : 64'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            m_minor[r_s] <= r_acc;
        end
        if (m_re) begin
            r_m_rd <= (m_raddr == '0) ? DET_W'(1) : m_minor[m_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= 4'd4;
            r_col    <= '0;
            r_gvld   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (g_we) begin
                r_gvld[g_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!row_end) begin
                            r_col <= col_nxt;
                        end else begin
                            r_col   <= '0;
                            r_y     <= i_item.y_value;
                            r_last  <= i_item.last_of_set;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_ACC_I;
                        end
                    end
                end
                S_ACC_I: begin
                    r_state <= S_ACC_XI;
                end
                S_ACC_XI: begin
                    r_xi    <= r_rb;
                    r_state <= S_ACC_RA;
                end
                S_ACC_RA: begin
                    r_state <= S_ACC_MUL;
                end
                S_ACC_MUL: begin
                    r_prod  <= r_xi * (j_is_n ? r_y : r_rb);
                    r_state <= S_ACC_WR;
                end
                S_ACC_WR: begin
                    if (!j_is_n) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_ACC_RA;
                    end else if (!i_is_last) begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= '0;
                        r_state <= S_ACC_I;
                    end else if (r_last) begin
                        r_cram  <= 1'b0;
                        r_s     <= MAX_COEFFS'(1);
                        r_state <= S_D_SET;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_D_SET: begin
                    r_acc   <= '0;
                    r_j     <= '0;
                    r_state <= S_D_RD;
                end
                S_D_RD: begin
                    if (s_bit) begin
                        r_odd   <= odd;
                        r_state <= S_D_LD;
                    end else if (j_is_last) begin
                        r_state <= S_D_WR;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_D_LD: begin
                    r_mag   <= g_mag;
                    r_neg   <= r_g_rd[63] ^ r_odd;
                    r_p     <= '0;
                    r_bit   <= '0;
                    r_state <= S_D_MUL;
                end
                S_D_MUL: begin
                    // Shift-and-add from the top bit of the entry magnitude.
                    r_p   <= (r_p <<< 1) + (r_mag[63] ? r_m_rd : DET_W'(0));
                    r_mag <= r_mag << 1;
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'd63) begin
                        r_state <= S_D_ADD;
                    end
                end
                S_D_ADD: begin
                    r_acc <= r_neg ? (r_acc - r_p) : (r_acc + r_p);
                    if (j_is_last) begin
                        r_state <= S_D_WR;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_D_RD;
                    end
                end
                S_D_WR: begin
                    if (!s_full) begin
                        r_s     <= r_s + MAX_COEFFS'(1);
                        r_state <= S_D_SET;
                    end else if (r_cram) begin
                        r_state <= S_D_DIV;
                    end else begin
                        r_det <= r_acc;
                        r_i   <= '0;
                        if (r_acc == '0) begin
                            r_state <= S_ZERO;
                        end else begin
                            r_cram  <= 1'b1;
                            r_s     <= MAX_COEFFS'(1);
                            r_state <= S_D_SET;
                        end
                    end
                end
                S_D_DIV: begin
                    if (div_res.done) begin
                        r_strobe          <= 1'b1;
                        r_out.coefficient <= div_res.coef;
                        r_out.coeff_index <= 3'(r_i);
                        r_out.singular    <= 1'b0;
                        r_out.last_coeff  <= i_is_last;
                        if (i_is_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_s     <= MAX_COEFFS'(1);
                            r_state <= S_D_SET;
                        end
                    end
                end
                S_ZERO: begin
                    r_strobe          <= 1'b1;
                    r_out.coefficient <= 32'sd0;
                    r_out.coeff_index <= 3'(r_i);
                    r_out.singular    <= 1'b1;
                    r_out.last_coeff  <= i_is_last;
                    if (i_is_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_FIN: begin
                    // Dropping the valid bits clears the accumulators for the next set.
                    r_gvld  <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lsq_divider #(
        .DET_W     (DET_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_det),
        .o_res   (div_res)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

>>> src/lsq_divider.sv
module lsq_divider #(
    parameter int DET_W     = 536,
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DET_W-1:0] i_num,
    input  logic signed [DET_W-1:0] i_den,
    output lsq_pkg::t_div_res       o_res
);

    localparam int DW = DET_W + FRAC_BITS + lsq_pkg::QUO_BITS + 2;
    localparam int QW = lsq_pkg::QUO_BITS + 1;

    typedef enum logic [4:0] {
        V_IDLE = 5'b00001,
        V_CMP  = 5'b00010,
        V_LOOP = 5'b00100,
        V_RND  = 5'b01000,
        V_OUT  = 5'b10000
    } t_vstate;

    t_vstate            r_state;
    logic [DW-1:0]      r_a;
    logic [DW-1:0]      r_b;
    logic [DW-1:0]      r_t;
    logic [QW-1:0]      r_q;
    logic [5:0]         r_k;
    logic               r_neg;
    logic               r_ovf;
    logic               r_done;
    logic signed [31:0] r_coef;

    logic [DET_W-1:0]   num_mag;
    logic [DET_W-1:0]   den_mag;
    logic [DW-1:0]      t_half;
    logic               big_neg;
    logic               big_pos;
    logic signed [31:0] coef_sat;

    assign num_mag = i_num[DET_W-1] ? DET_W'(-i_num) : DET_W'(i_num);
    assign den_mag = i_den[DET_W-1] ? DET_W'(-i_den) : DET_W'(i_den);
    assign t_half  = r_t >> 1;

    always_comb begin
        big_neg = r_ovf || (r_q >= QW'(64'h8000_0000));
        big_pos = r_ovf || (r_q > QW'(64'h7FFF_FFFF));
        if (r_neg) begin
            coef_sat = big_neg ? lsq_pkg::COEF_MIN : -(32'(r_q));
        end else begin
            coef_sat = big_pos ? lsq_pkg::COEF_MAX : 32'(r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                V_IDLE: begin
                    if (i_start) begin
                        r_state <= V_CMP;
                    end
                end
                V_CMP: begin
                    if (r_a >= r_t) begin
                        r_state <= V_OUT;
                    end else begin
                        r_state <= V_LOOP;
                    end
                end
                V_LOOP: begin
                    if (r_k == 6'd0) begin
                        r_state <= V_RND;
                    end
                end
                V_RND: begin
                    r_state <= V_OUT;
                end
                V_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= V_IDLE;
                end
                default: r_state <= V_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            V_IDLE: begin
                r_a   <= DW'(num_mag) << FRAC_BITS;
                r_b   <= DW'(den_mag);
                r_t   <= DW'(den_mag) << lsq_pkg::QUO_BITS;
                r_neg <= i_num[DET_W-1] ^ i_den[DET_W-1];
            end
            V_CMP: begin
                r_ovf <= (r_a >= r_t);
                r_q   <= '0;
                r_k   <= 6'(lsq_pkg::QUO_BITS - 1);
            end
            V_LOOP: begin
                // Restoring division, one quotient bit per cycle.
                if (r_a >= t_half) begin
                    r_a      <= r_a - t_half;
                    r_q[r_k] <= 1'b1;
                end
                r_t <= t_half;
                r_k <= r_k - 6'd1;
            end
            V_RND: begin
                // Twice the remainder against the divisor rounds half away from zero.
                if ((r_a << 1) >= r_b) begin
                    r_q <= r_q + QW'(1);
                end
            end
            V_OUT: begin
                r_coef <= coef_sat;
            end
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.coef = r_coef;

endmodule
